FILE: rtl/core/hni_pkg.sv
// Shared types, codes and defaults for the hazard NOP inserter.
package hni_pkg;

	localparam int WINDOW_DEPTH_DEF = 4;
	localparam int BRANCH_SLOTS_DEF = 4;

	// Wide enough for every result position with the default parameters.
	localparam int STEP_W = 4;

	typedef enum logic [2:0] {
		KIND_NOP    = 3'd0,
		KIND_DATA   = 3'd1,
		KIND_MEM    = 3'd2,
		KIND_BRANCH = 3'd3,
		KIND_LABEL  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OKIND_NOP   = 2'd0,
		OKIND_INSTR = 2'd1,
		OKIND_LABEL = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  rnum;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]  kind;
		logic        reads_dest;
		logic        has_third;
		logic [3:0]  dest_reg;
		logic [3:0]  src_one;
		logic        src_one_is_reg;
		logic [3:0]  src_two;
		logic        src_two_is_reg;
		logic [31:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_value;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] pre_nops;
		entry_t            new_entry;
	} plan_t;

endpackage

FILE: rtl/core/hazard_nop_inserter.sv
// The result sequencer over the input register fills the output register, which parts the sides.
// Throughput: one result per cycle while the output is not stalled; an item gives one to
// WINDOW_DEPTH+1 results for data and memory ops, BRANCH_SLOTS+1 or +2 for a branch, one for a NOP
// and none for a label; an item waits in the input register until its last result is sent.
// Reset clears the window, the pending label flag and both valid flags; the label value is not reset.
module hazard_nop_inserter #(
	parameter int WINDOW_DEPTH = hni_pkg::WINDOW_DEPTH_DEF,
	parameter int BRANCH_SLOTS = hni_pkg::BRANCH_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hni_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output hni_pkg::out_item_t  result
);

	localparam int SW = hni_pkg::STEP_W;

	logic                               valid_s1;
	hni_pkg::in_item_t                  item_s1;
	logic [SW-1:0]                      step_q;
	logic                               result_valid_q;
	hni_pkg::out_item_t                 result_q;

	hni_pkg::entry_t [WINDOW_DEPTH-1:0] window;
	logic                               label_pending;
	logic [31:0]                        label_value;
	hni_pkg::plan_t                     plan;

	logic                               is_instr;
	logic                               is_branch;
	logic                               has_label;
	logic [SW-1:0]                      label_ext;
	logic [SW-1:0]                      label_pos;
	logic [SW-1:0]                      instr_pos;
	logic [SW-1:0]                      total;
	logic                               out_free;
	logic                               fire;
	logic                               is_last;
	logic                               done;
	hni_pkg::out_item_t                 next_result;

	hni_hazard #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_hazard (
		.item   (item_s1),
		.window (window),
		.plan   (plan)
	);

	hni_state #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.BRANCH_SLOTS (BRANCH_SLOTS)
	) u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (done),
		.item          (item_s1),
		.plan          (plan),
		.window        (window),
		.label_pending (label_pending),
		.label_value   (label_value)
	);

	assign is_instr  = (item_s1.kind == hni_pkg::KIND_DATA) ||
		(item_s1.kind == hni_pkg::KIND_MEM);
	assign is_branch = (item_s1.kind == hni_pkg::KIND_BRANCH);
	assign has_label = label_pending && (is_instr || is_branch);
	assign label_ext = {{(SW-1){1'b0}}, has_label};
	assign label_pos = is_branch ? '0 : plan.pre_nops;
	assign instr_pos = label_pos + label_ext;

	always_comb begin
		case (item_s1.kind)
			hni_pkg::KIND_NOP:    total = SW'(1);
			hni_pkg::KIND_BRANCH: total = label_ext + SW'(BRANCH_SLOTS + 1);
			hni_pkg::KIND_DATA,
			hni_pkg::KIND_MEM:    total = plan.pre_nops + label_ext + SW'(1);
			default:              total = '0;
		endcase
	end

	assign out_free   = ~result_valid_q | ~result_stall;
	assign fire       = valid_s1 && (total != '0) && out_free;
	assign is_last    = (step_q == total - SW'(1));
	assign done       = valid_s1 && ((total == '0) || (fire && is_last));
	assign item_stall = valid_s1 && ~done;

	always_comb begin
		next_result.out_kind  = hni_pkg::OKIND_NOP;
		next_result.out_value = '0;
		next_result.last      = is_last;
		if (item_s1.kind != hni_pkg::KIND_NOP) begin
			if (has_label && step_q == label_pos) begin
				next_result.out_kind  = hni_pkg::OKIND_LABEL;
				next_result.out_value = label_value;
			end else if (step_q == instr_pos) begin
				next_result.out_kind  = hni_pkg::OKIND_INSTR;
				next_result.out_value = item_s1.item_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (done) begin
				step_q <= '0;
			end else if (fire) begin
				step_q <= step_q + SW'(1);
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/core/hni_hazard.sv
// Hazard check of one instruction against the window of recent destinations.
module hni_hazard #(
	parameter int WINDOW_DEPTH = hni_pkg::WINDOW_DEPTH_DEF
) (
	input  hni_pkg::in_item_t                    item,
	input  hni_pkg::entry_t [WINDOW_DEPTH-1:0]   window,
	output hni_pkg::plan_t                       plan
);

	localparam int IDX_W = $clog2(WINDOW_DEPTH);

	logic             rd_dest;
	logic             rd_one;
	logic             rd_two;
	logic             hit;
	logic [IDX_W-1:0] idx;

	assign rd_dest = item.reads_dest;
	assign rd_one  = item.src_one_is_reg;
	assign rd_two  = (item.kind == hni_pkg::KIND_DATA) && item.has_third && item.src_two_is_reg;

	// The nearest matching entry wins, so the scan ends on the lowest position.
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
			if (window[i].valid && ((rd_dest && window[i].rnum == item.dest_reg) ||
					(rd_one && window[i].rnum == item.src_one) ||
					(rd_two && window[i].rnum == item.src_two))) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		plan.pre_nops = hit ?
			(hni_pkg::STEP_W'(WINDOW_DEPTH - 1) - hni_pkg::STEP_W'(idx)) : '0;
		plan.new_entry.valid = ~item.reads_dest;
		plan.new_entry.rnum  = item.dest_reg;
	end

endmodule

FILE: rtl/core/hni_state.sv
// Destination window and pending label, updated once each item completes.
module hni_state #(
	parameter int WINDOW_DEPTH = hni_pkg::WINDOW_DEPTH_DEF,
	parameter int BRANCH_SLOTS = hni_pkg::BRANCH_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 commit,
	input  hni_pkg::in_item_t                    item,
	input  hni_pkg::plan_t                       plan,
	output hni_pkg::entry_t [WINDOW_DEPTH-1:0]   window,
	output logic                                 label_pending,
	output logic [31:0]                          label_value
);

	localparam int WIN_W = WINDOW_DEPTH * hni_pkg::ENTRY_W;

	hni_pkg::entry_t [WINDOW_DEPTH-1:0] window_q;
	logic                               label_pending_q;
	logic [31:0]                        label_value_q;
	logic [hni_pkg::STEP_W-1:0]         shift_amt;
	logic [WIN_W-1:0]                   shifted;
	hni_pkg::entry_t [WINDOW_DEPTH-1:0] window_next;
	logic                               is_instr;

	assign is_instr = (item.kind == hni_pkg::KIND_DATA) || (item.kind == hni_pkg::KIND_MEM);

	always_comb begin
		case (item.kind)
			hni_pkg::KIND_NOP:    shift_amt = hni_pkg::STEP_W'(1);
			hni_pkg::KIND_BRANCH: shift_amt = hni_pkg::STEP_W'(BRANCH_SLOTS + 1);
			hni_pkg::KIND_DATA,
			hni_pkg::KIND_MEM:    shift_amt = plan.pre_nops + hni_pkg::STEP_W'(1);
			default:              shift_amt = '0;
		endcase
		shifted = WIN_W'(window_q) << (hni_pkg::ENTRY_W * shift_amt);
		window_next = shifted;
		if (is_instr) begin
			window_next[0] = plan.new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= '0;
			label_pending_q <= 1'b0;
		end else if (commit) begin
			window_q <= window_next;
			if (item.kind == hni_pkg::KIND_LABEL) begin
				label_pending_q <= 1'b1;
			end else if (is_instr || item.kind == hni_pkg::KIND_BRANCH) begin
				label_pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && item.kind == hni_pkg::KIND_LABEL) begin
			label_value_q <= item.item_value;
		end
	end

	assign window        = window_q;
	assign label_pending = label_pending_q;
	assign label_value   = label_value_q;

endmodule
